>>> src/cbps_pkg.sv
// Shared types, constants and helpers for the cubic Bezier path smoother.
package cbps_pkg;

	localparam int SAMPLES_PER_SEGMENT_DEF = 20;
	localparam int COORD_W = 16;
	localparam int CMDQ_DEPTH = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic path_end;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic run_last;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef point_t [3:0] quad_t;

	typedef enum logic [0:0] {
		CMD_SEG,
		CMD_PASS
	} cmd_kind_t;

	// pass_last: index of the final passed-through point
	typedef struct packed {
		cmd_kind_t kind;
		logic [1:0] pass_last;
		quad_t pts;
	} cmd_t;

	// trailing zero count, elaboration only
	function automatic int ctz(input int v);
		int n;
		logic hit;
		n = 0;
		hit = 1'b0;
		for (int i = 0; i < 31; i++) begin
			if (!hit && v[i]) begin
				hit = 1'b1;
			end else if (!hit) begin
				n = n + 1;
			end
		end
		return n;
	endfunction

endpackage

>>> src/cubic_bezier_path_smoother_core.sv
// Cubic Bezier path smoother top level.
// A command passes the queue, then stages s1 to s6 and the output register.
// Throughput: one result per cycle unless stalled; a segment-closing point holds the
// sample engine for SAMPLES_PER_SEGMENT results, a short path end for 1 to 3 results.
// Points are taken every cycle until the 2-entry command queue fills.
// Reset (arst_n low) clears path counters, queue and valids; held points do not reset.
module cubic_bezier_path_smoother_core #(
	parameter int SAMPLES_PER_SEGMENT = cbps_pkg::SAMPLES_PER_SEGMENT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pt_valid,
	output logic                pt_stall,
	input  cbps_pkg::in_item_t  pt,
	output logic                smp_valid,
	input  logic                smp_stall,
	output cbps_pkg::out_item_t smp
);

	logic push, q_full, pop, head_vld;
	cbps_pkg::cmd_t push_cmd, head;

	cbps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.pt       (pt),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	cbps_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head_vld (head_vld),
		.head     (head)
	);

	cbps_back #(
		.SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_vld  (head_vld),
		.pop       (pop),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

endmodule

>>> src/cbps_front.sv
// Front end: point history, segment detection, command generation.
module cbps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pt_valid,
	output logic                pt_stall,
	input  cbps_pkg::in_item_t  pt,
	input  logic                q_full,
	output logic                push,
	output cbps_pkg::cmd_t      push_cmd
);

	cbps_pkg::point_t held_q [3];
	logic [2:0] count_q, count_d;
	logic [1:0] phase_q, phase_d;
	cbps_pkg::point_t cur;
	logic acc;
	logic want;

	assign pt_stall = q_full;
	assign acc = pt_valid && !q_full;
	assign push = acc && want;

	always_comb begin
		cur.x = pt.point_x;
		cur.y = pt.point_y;
		want = 1'b0;
		count_d = count_q;
		phase_d = phase_q;
		push_cmd.kind = cbps_pkg::CMD_SEG;
		push_cmd.pass_last = count_q[1:0];
		push_cmd.pts = {cur, held_q[2], held_q[1], held_q[0]};
		if (count_q < 3'd3) begin
			if (pt.path_end) begin
				want = 1'b1;
				push_cmd.kind = cbps_pkg::CMD_PASS;
				case (count_q[1:0])
					2'd0: begin
						push_cmd.pts = {cur, cur, cur, cur};
					end
					2'd1: begin
						push_cmd.pts = {cur, cur, cur, held_q[2]};
					end
					2'd2: begin
						push_cmd.pts = {cur, cur, held_q[2], held_q[1]};
					end
					default: begin
						push_cmd.pts = {cur, cur, cur, cur};
					end
				endcase
			end else begin
				count_d = count_q + 3'd1;
			end
		end else if (count_q == 3'd3) begin
			want = 1'b1;
			count_d = 3'd4;
			phase_d = '0;
		end else if (phase_q >= 2'd2) begin
			want = 1'b1;
			phase_d = '0;
		end else begin
			phase_d = phase_q + 2'd1;
		end
		if (pt.path_end) begin
			count_d = '0;
			phase_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (acc) begin
			count_q <= count_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			held_q[0] <= held_q[1];
			held_q[1] <= held_q[2];
			held_q[2] <= cur;
		end
	end

endmodule

>>> src/cbps_cmdq.sv
// Short command queue between front end and sample engine.
module cbps_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cbps_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_vld,
	output cbps_pkg::cmd_t  head
);

	localparam int DEPTH = cbps_pkg::CMDQ_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cbps_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> src/cbps_back.sv
// Sample engine: beat sequencer and Bernstein weight / divide pipeline.
module cbps_back #(
	parameter int SAMPLES_PER_SEGMENT = cbps_pkg::SAMPLES_PER_SEGMENT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbps_pkg::cmd_t      head,
	input  logic                head_vld,
	output logic                pop,
	output logic                smp_valid,
	input  logic                smp_stall,
	output cbps_pkg::out_item_t smp
);

	localparam int N = SAMPLES_PER_SEGMENT;
	localparam int CW = cbps_pkg::COORD_W;
	localparam int KW = $clog2(N + 1);
	localparam int K2W = 2 * KW;
	localparam int W3W = 3 * KW + 2;
	localparam int RUN_MAX = (N > 4) ? N : 4;
	localparam int JW = $clog2(RUN_MAX);
	localparam int DEN = N * N * N;
	localparam int WW = $clog2(DEN + 1);
	localparam int NUM_W = $clog2(DEN) + CW + 1;
	localparam int TZ = cbps_pkg::ctz(DEN);
	localparam int DEN_ODD = DEN >> TZ;
	localparam int MAG_W = NUM_W - 1 - TZ;
	localparam int SH = MAG_W + $clog2(DEN_ODD);
	localparam int RECIP_W = MAG_W + 1;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int HALF = DEN / 2;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SH) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));

	function automatic logic [CW-1:0] sat_signed(input logic neg, input logic [CW:0] mag);
		logic [CW:0] lim_pos;
		logic [CW:0] lim_neg;
		logic [CW:0] negv;
		lim_pos = {2'b00, {(CW-1){1'b1}}};
		lim_neg = {2'b01, {(CW-1){1'b0}}};
		negv = ~mag + 1'b1;
		if (neg) begin
			sat_signed = (mag > lim_neg) ? lim_neg[CW-1:0] : negv[CW-1:0];
		end else begin
			sat_signed = (mag > lim_pos) ? lim_pos[CW-1:0] : mag[CW-1:0];
		end
	endfunction

	logic en;
	logic [JW-1:0] j_q;
	logic [JW-1:0] last_idx;
	logic seg, beat_last;
	logic [KW-1:0] beat_k;
	cbps_pkg::quad_t beat_pts;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_q;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [KW-1:0] t_s1, u_s1;
	logic [K2W-1:0] t2_s1, u2_s1;
	cbps_pkg::quad_t pts_s1, pts_s2;
	logic [WW-1:0] w_s2 [4];
	logic signed [NUM_W-1:0] px_s3 [4];
	logic signed [NUM_W-1:0] py_s3 [4];
	logic signed [NUM_W-1:0] sx_s4, sy_s4;
	logic signed [NUM_W-1:0] mx, my, ax, ay;
	logic [MAG_W-1:0] magx_s5, magy_s5;
	logic negx_s5, negy_s5, negx_s6, negy_s6;
	logic [PROD_W-1:0] prx_s6, pry_s6;
	cbps_pkg::out_item_t res;
	cbps_pkg::out_item_t smp_q;

	assign en = !vld_q || !smp_stall;
	assign smp_valid = vld_q;
	assign smp = smp_q;

	// passed-through point uses k = 0, so w0 = N^3 and the point comes back exact
	always_comb begin
		seg = (head.kind == cbps_pkg::CMD_SEG);
		last_idx = seg ? JW'(N - 1) : JW'(head.pass_last);
		beat_last = (j_q == last_idx);
		pop = head_vld && en && beat_last;
		beat_k = seg ? KW'(j_q) : '0;
		beat_pts = seg ? head.pts : {4{head.pts[j_q[1:0]]}};
	end

	always_comb begin
		mx = sx_s4[NUM_W-1] ? -sx_s4 : sx_s4;
		my = sy_s4[NUM_W-1] ? -sy_s4 : sy_s4;
		ax = mx + NUM_W'(HALF);
		ay = my + NUM_W'(HALF);
		res.out_x = sat_signed(negx_s6, prx_s6[SH +: CW+1]);
		res.out_y = sat_signed(negy_s6, pry_s6[SH +: CW+1]);
		res.run_last = last_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			if (head_vld) begin
				j_q <= beat_last ? '0 : j_q + 1'b1;
			end
			vld_s1 <= head_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= beat_k;
			u_s1 <= KW'(N) - beat_k;
			t2_s1 <= K2W'(beat_k) * K2W'(beat_k);
			u2_s1 <= K2W'(KW'(N) - beat_k) * K2W'(KW'(N) - beat_k);
			pts_s1 <= beat_pts;
			last_s1 <= beat_last;

			w_s2[0] <= WW'(W3W'(u2_s1) * W3W'(u_s1));
			w_s2[1] <= WW'(W3W'(3) * W3W'(u2_s1) * W3W'(t_s1));
			w_s2[2] <= WW'(W3W'(3) * W3W'(t2_s1) * W3W'(u_s1));
			w_s2[3] <= WW'(W3W'(t2_s1) * W3W'(t_s1));
			pts_s2 <= pts_s1;
			last_s2 <= last_s1;

			for (int i = 0; i < 4; i++) begin
				px_s3[i] <= NUM_W'(signed'({1'b0, w_s2[i]})) * NUM_W'(pts_s2[i].x);
				py_s3[i] <= NUM_W'(signed'({1'b0, w_s2[i]})) * NUM_W'(pts_s2[i].y);
			end
			last_s3 <= last_s2;

			sx_s4 <= px_s3[0] + px_s3[1] + px_s3[2] + px_s3[3];
			sy_s4 <= py_s3[0] + py_s3[1] + py_s3[2] + py_s3[3];
			last_s4 <= last_s3;

			magx_s5 <= ax[NUM_W-2:TZ];
			magy_s5 <= ay[NUM_W-2:TZ];
			negx_s5 <= sx_s4[NUM_W-1];
			negy_s5 <= sy_s4[NUM_W-1];
			last_s5 <= last_s4;

			prx_s6 <= PROD_W'(magx_s5) * PROD_W'(RECIP);
			pry_s6 <= PROD_W'(magy_s5) * PROD_W'(RECIP);
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			last_s6 <= last_s5;

			smp_q <= res;
		end
	end

endmodule

>>> src/cbps_checker.sv
// Port-level checker for the path smoother, bound to the top level.
module cbps_checker #(
	parameter int SAMPLES_PER_SEGMENT = cbps_pkg::SAMPLES_PER_SEGMENT_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                pt_valid,
	input logic                pt_stall,
	input cbps_pkg::in_item_t  pt,
	input logic                smp_valid,
	input logic                smp_stall,
	input cbps_pkg::out_item_t smp
);

	localparam int N = SAMPLES_PER_SEGMENT;
	localparam int RUN_MAX = (N > 4) ? N : 4;
	localparam int RW = $clog2(RUN_MAX + 1);

	logic [RW-1:0] run_q;
	logic smp_acc, pt_acc;

	assign smp_acc = smp_valid && !smp_stall;
	assign pt_acc = pt_valid && !pt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (smp_acc) begin
			run_q <= smp.run_last ? '0 : run_q + 1'b1;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !smp_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> smp_valid && $stable(smp))
		else $error("stalled result changed");

	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc && (run_q == RW'(RUN_MAX - 1)) |-> smp.run_last)
		else $error("result run too long");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc && smp.run_last |-> (run_q == RW'(N - 1)) || (run_q < RW'(4)))
		else $error("result run has bad length");

	a_pt_seen: assert property (@(posedge clk) disable iff (!arst_n)
		pt_acc |-> !$isunknown(pt.path_end))
		else $error("unknown path end on request");

endmodule

bind cubic_bezier_path_smoother_core cbps_checker #(
	.SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT)
) u_cbps_checker (.*);

>>> sim/cubic_bezier_path_smoother_core_test.sv
// Self-checking testbench for the cubic Bezier path smoother: directed table, random paths.
module cubic_bezier_path_smoother_core_test;

	localparam int NSAMP = cbps_pkg::SAMPLES_PER_SEGMENT_DEF;
	localparam longint CUBE = NSAMP * NSAMP * NSAMP;
	localparam int RAND_POINTS = 300;
	localparam int CALM_FROM = 240;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [15:0] MAXC = 16'sh7fff;
	localparam logic signed [15:0] MINC = 16'sh8000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic last;
		logic typed;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
	} plan_row_t;

	// typed rows: every sample of that request carries (wx, wy)
	localparam plan_row_t PLAN [22] = '{
		'{MAXC, MINC, 1'b1, 1'b1, MAXC, MINC},
		'{-16'sd1, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{16'sd0, MINC, 1'b1, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{16'sd1234, -16'sd77, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MAXC, 1'b1, 1'b1, MAXC, MAXC},
		'{MINC, MINC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MINC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MINC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MINC, 1'b0, 1'b1, MINC, MINC},
		'{16'sd5, 16'sd5, 1'b1, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MINC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MINC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{16'sd3, -16'sd3, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MINC, MAXC, 1'b0, 1'b0, 16'sd0, 16'sd0},
		'{MAXC, MINC, 1'b1, 1'b0, 16'sd0, 16'sd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic smp_stall = 1'b0;
	cbps_pkg::in_item_t pt = '0;
	logic pt_stall;
	logic smp_valid;
	cbps_pkg::out_item_t smp;

	cbps_pkg::point_t held_pts [3];
	logic [2:0] pts_seen = '0;
	logic [1:0] since_seg = '0;
	cbps_pkg::out_item_t step_samples [$];
	cbps_pkg::out_item_t want_samples [$];
	int err_count = 0;
	int cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	cubic_bezier_path_smoother_core #(
		.SAMPLES_PER_SEGMENT(NSAMP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt(pt),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.smp(smp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [15:0] round_sat(longint num);
		longint q;
		if (num >= 0) begin
			q = (num + CUBE / 2) / CUBE;
		end else begin
			q = -((-num + CUBE / 2) / CUBE);
		end
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		return q[15:0];
	endfunction

	function automatic void sample_segment(cbps_pkg::point_t p3);
		longint t, u, w0, w1, w2, w3, nx, ny;
		cbps_pkg::out_item_t s;
		for (int k = 0; k < NSAMP; k++) begin
			t = k;
			u = NSAMP - k;
			w0 = u * u * u;
			w1 = 3 * u * u * t;
			w2 = 3 * u * t * t;
			w3 = t * t * t;
			nx = w0 * held_pts[0].x + w1 * held_pts[1].x + w2 * held_pts[2].x + w3 * p3.x;
			ny = w0 * held_pts[0].y + w1 * held_pts[1].y + w2 * held_pts[2].y + w3 * p3.y;
			s.out_x = round_sat(nx);
			s.out_y = round_sat(ny);
			s.run_last = 1'b0;
			step_samples = {step_samples, s};
		end
	endfunction

	function automatic void bezier_predict(cbps_pkg::in_item_t req);
		cbps_pkg::point_t cur;
		cbps_pkg::out_item_t s;
		cur.x = req.point_x;
		cur.y = req.point_y;
		step_samples.delete();
		if (pts_seen < 3) begin
			if (req.path_end) begin
				for (int i = 3 - pts_seen; i < 3; i++) begin
					s.out_x = held_pts[i].x;
					s.out_y = held_pts[i].y;
					s.run_last = 1'b0;
					step_samples = {step_samples, s};
				end
				s.out_x = cur.x;
				s.out_y = cur.y;
				s.run_last = 1'b0;
				step_samples = {step_samples, s};
			end else begin
				pts_seen++;
			end
		end else if (pts_seen == 3) begin
			sample_segment(cur);
			pts_seen = 3'd4;
			since_seg = '0;
		end else if (since_seg >= 2) begin
			sample_segment(cur);
			since_seg = '0;
		end else begin
			since_seg++;
		end
		held_pts[0] = held_pts[1];
		held_pts[1] = held_pts[2];
		held_pts[2] = cur;
		if (req.path_end) begin
			pts_seen = '0;
			since_seg = '0;
		end
		if (step_samples.size() > 0) begin
			step_samples[step_samples.size() - 1].run_last = 1'b1;
		end
	endfunction

	function automatic logic signed [15:0] rand_coord();
		int r;
		r = $urandom_range(0, 63);
		case ($urandom_range(0, 7))
			0: begin
				return MAXC;
			end
			1: begin
				return MINC;
			end
			2: begin
				return 16'sd0;
			end
			3: begin
				return 16'(r - 32);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic send_point(cbps_pkg::in_item_t req, logic typed, logic signed [15:0] wx,
			logic signed [15:0] wy);
		cbps_pkg::out_item_t s;
		bezier_predict(req);
		foreach (step_samples[i]) begin
			s = step_samples[i];
			if (typed) begin
				s.out_x = wx;
				s.out_y = wy;
			end
			want_samples = {want_samples, s};
		end
		pt <= req;
		pt_valid <= 1'b1;
		@(posedge clk);
		while (pt_stall) begin
			@(posedge clk);
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		cbps_pkg::out_item_t w;
		if (arst_n && smp_valid && !smp_stall) begin
			if (want_samples.size() == 0) begin
				err_count++;
				$display("%0t: unexpected sample x %0d y %0d last %0b", $time,
					smp.out_x, smp.out_y, smp.run_last);
			end else begin
				w = want_samples.pop_front();
				if (smp.out_x !== w.out_x) begin
					err_count++;
					$display("%0t: out_x expected %0d got %0d", $time, w.out_x, smp.out_x);
				end
				if (smp.out_y !== w.out_y) begin
					err_count++;
					$display("%0t: out_y expected %0d got %0d", $time, w.out_y, smp.out_y);
				end
				if (smp.run_last !== w.run_last) begin
					err_count++;
					$display("%0t: run_last expected %0b got %0b", $time, w.run_last,
						smp.run_last);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			smp_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			smp_stall <= 1'b1;
		end else begin
			smp_stall <= 1'b0;
		end
	end

	initial begin
		cbps_pkg::in_item_t req;
		int sent;
		int plen;
		for (int i = 0; i < 3; i++) begin
			held_pts[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (PLAN[i]) begin
			req.point_x = PLAN[i].x;
			req.point_y = PLAN[i].y;
			req.path_end = PLAN[i].last;
			send_point(req, PLAN[i].typed, PLAN[i].wx, PLAN[i].wy);
		end
		sent = 0;
		while (sent < RAND_POINTS) begin
			plen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 13);
			for (int j = 0; j < plen; j++) begin
				req.point_x = rand_coord();
				req.point_y = rand_coord();
				req.path_end = (j == plen - 1);
				calm = (sent >= CALM_FROM);
				send_point(req, 1'b0, 16'sd0, 16'sd0);
				sent++;
			end
		end
		pt_valid <= 1'b0;
		while (want_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
